>>> rtl/core/preemptive_priority_scheduler_top_assert.svh
// ----------------------------------------------------------------------------
// scheduler assertion macros
// concurrent checks clocked on clock, masked while reset is high
// ----------------------------------------------------------------------------
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_TOP_ASSERT_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_TOP_ASSERT_SVH

// same-cycle implication
`define PPS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PPS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/pps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_pkg
// shared types and field widths of the priority scheduler
// ----------------------------------------------------------------------------
package pps_pkg;

   localparam int ARR_W   = 16;
   localparam int BURST_W = 8;
   localparam int PRIO_W  = 8;
   localparam int TIME_W  = 17;
   localparam int NUM_W   = 4;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SCAN,
      ST_UPDATE,
      ST_RSCAN,
      ST_ROUT
   } phase_type;

   // one queued task beat, classified by the front end
   typedef struct packed {
      logic [ARR_W-1:0]   arrival_time;
      logic [BURST_W-1:0] burst_time;
      logic [PRIO_W-1:0]  task_priority;
      logic               last_task;
      logic               store;
   } task_type;

endpackage

>>> rtl/core/pps_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_req_if
// task load channel
// ----------------------------------------------------------------------------
interface pps_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] arrival_time;
   logic [7:0]  burst_time;
   logic [7:0]  task_priority;
   logic        last_task;

   modport source (output valid, arrival_time, burst_time, task_priority, last_task,
                   input ready);
   modport sink   (input valid, arrival_time, burst_time, task_priority, last_task,
                   output ready);
endinterface

>>> rtl/core/pps_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_rsp_if
// task report channel
// ----------------------------------------------------------------------------
interface pps_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  task_number;
   logic [16:0] finish_time;
   logic [16:0] turnaround;
   logic [16:0] waiting;
   logic        last_report;

   modport source (output valid, task_number, finish_time, turnaround, waiting,
                   last_report, input ready);
   modport sink   (input valid, task_number, finish_time, turnaround, waiting,
                   last_report, output ready);
endinterface

>>> rtl/core/pps_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module pps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/core/pps_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_front
// accepts task beats, flags overflow, and queues them two deep
// ----------------------------------------------------------------------------
module pps_front #(
   parameter int MAX_TASKS = 16,
   localparam int CW = $clog2(MAX_TASKS + 1)
) (
   input  logic              clock,
   input  logic              reset,
   pps_req_if.sink           req_ch,
   output logic              q_valid,
   input  logic              q_pop,
   output pps_pkg::task_type q_entry
);
   import pps_pkg::*;

   logic [CW-1:0] fcnt_ff, fcnt_in;
   task_type      slot_ff [2];
   logic          head_ff, head_in, tail_ff, tail_in;
   logic [1:0]    fill_ff, fill_in;
   logic          accept;
   task_type      beat;

   assign req_ch.ready = (fill_ff != 2'd2);
   assign accept       = req_ch.valid && req_ch.ready;
   assign q_valid      = (fill_ff != 2'd0);
   assign q_entry      = slot_ff[head_ff];

   always_comb begin
      beat.arrival_time  = req_ch.arrival_time;
      beat.burst_time    = req_ch.burst_time;
      beat.task_priority = req_ch.task_priority;
      beat.last_task     = req_ch.last_task;
      beat.store         = (fcnt_ff != CW'(MAX_TASKS));
      fcnt_in = fcnt_ff;
      if (accept) begin
         if (req_ch.last_task) begin
            fcnt_in = '0;
         end else if (beat.store) begin
            fcnt_in = fcnt_ff + CW'(1);
         end
      end
      head_in = head_ff ^ (q_pop && q_valid);
      tail_in = tail_ff ^ accept;
      fill_in = fill_ff + {1'b0, accept} - {1'b0, q_pop && q_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fcnt_ff <= '0;
         head_ff <= 1'b0;
         tail_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         fcnt_ff <= fcnt_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
      if (accept) begin
         slot_ff[tail_ff] <= beat;
      end
   end
endmodule

>>> rtl/core/pps_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_back
// task store, tick simulation by scanning, and arrival ordered reports
// ----------------------------------------------------------------------------
module pps_back #(
   parameter int MAX_TASKS = 16,
   localparam int CW = $clog2(MAX_TASKS + 1),
   localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_pop,
   input  pps_pkg::task_type q_entry,
   pps_rsp_if.source         rsp_ch
);
   import pps_pkg::*;
   `include "preemptive_priority_scheduler_top_assert.svh"

   localparam int SW = ARR_W + BURST_W + PRIO_W;
   localparam int DW = BURST_W + TIME_W;

   phase_type state_ff, state_in;

   logic [CW-1:0]      cnt_ff, cnt_in, scan_ff, scan_in, ocnt_ff, ocnt_in;
   logic [TIME_W-1:0]  t_ff, t_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [IW-1:0]      rd_idx_ff, rd_idx_in;
   logic               found_ff, found_in, pend_ff, pend_in;
   logic [IW-1:0]      best_idx_ff, best_idx_in;
   logic [PRIO_W-1:0]  best_pr_ff, best_pr_in;
   logic [ARR_W-1:0]   best_arr_ff, best_arr_in;
   logic [BURST_W-1:0] best_rem_ff, best_rem_in, best_bur_ff, best_bur_in;
   logic [TIME_W-1:0]  best_fin_ff, best_fin_in;
   logic [ARR_W-1:0]   next_arr_ff, next_arr_in;
   logic               prev_vld_ff, prev_vld_in;
   logic [ARR_W-1:0]   prev_arr_ff, prev_arr_in;
   logic [IW-1:0]      prev_idx_ff, prev_idx_in;

   logic               rsp_vld_ff, rsp_vld_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [TIME_W-1:0]  fin_ff, fin_in, tat_ff, tat_in, wt_ff, wt_in;
   logic               last_ff, last_in;

   logic               st_we, dy_we;
   logic [IW-1:0]      st_wa, dy_wa;
   logic [SW-1:0]      st_wd, st_rd;
   logic [DW-1:0]      dy_wd, dy_rd;

   logic [ARR_W-1:0]   e_arr;
   logic [BURST_W-1:0] e_bur, e_rem;
   logic [PRIO_W-1:0]  e_pr;
   logic [TIME_W-1:0]  e_fin;
   logic               scan_done, rsp_take, popped;
   logic [TIME_W-1:0]  tat_calc;

   assign e_arr = st_rd[SW-1 -: ARR_W];
   assign e_bur = st_rd[PRIO_W +: BURST_W];
   assign e_pr  = st_rd[PRIO_W-1:0];
   assign e_rem = dy_rd[DW-1 -: BURST_W];
   assign e_fin = dy_rd[TIME_W-1:0];

   assign scan_done = (scan_ff == cnt_ff) && !rd_vld_ff;
   assign rsp_take  = rsp_vld_ff && rsp_ch.ready;
   assign q_pop     = (state_ff == ST_LOAD);
   assign popped    = q_pop && q_valid;
   assign tat_calc  = best_fin_ff - {1'b0, best_arr_ff};

   // static fields written once per task, dynamic fields by the scheduler too
   pps_ram #(.WIDTH(SW), .DEPTH(MAX_TASKS)) u_static (
      .clock(clock), .wr_en(st_we), .wr_addr(st_wa), .wr_data(st_wd),
      .rd_addr(scan_ff[IW-1:0]), .rd_data(st_rd));

   pps_ram #(.WIDTH(DW), .DEPTH(MAX_TASKS)) u_dynamic (
      .clock(clock), .wr_en(dy_we), .wr_addr(dy_wa), .wr_data(dy_wd),
      .rd_addr(scan_ff[IW-1:0]), .rd_data(dy_rd));

   always_comb begin
      st_we = popped && q_entry.store;
      st_wa = cnt_ff[IW-1:0];
      st_wd = {q_entry.arrival_time, q_entry.burst_time, q_entry.task_priority};
      dy_we = st_we;
      dy_wa = cnt_ff[IW-1:0];
      dy_wd = {q_entry.burst_time, 1'b0, q_entry.arrival_time};
      if (state_ff == ST_UPDATE) begin
         dy_we = 1'b1;
         dy_wa = best_idx_ff;
         dy_wd = {best_rem_ff - BURST_W'(1),
                  (best_rem_ff == BURST_W'(1)) ? t_ff + TIME_W'(1) : best_fin_ff};
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (popped && q_entry.last_task) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               if (found_ff) begin
                  state_in = ST_UPDATE;
               end else if (!pend_ff) begin
                  state_in = ST_RSCAN;
               end
            end
         end
         ST_UPDATE: state_in = ST_SCAN;
         ST_RSCAN: begin
            if (scan_done) begin
               state_in = found_ff ? ST_ROUT : ST_LOAD;
            end
         end
         ST_ROUT: begin
            if (rsp_take) begin
               state_in = last_ff ? ST_LOAD : ST_RSCAN;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // datapath next values
   always_comb begin
      cnt_in      = cnt_ff;
      t_in        = t_ff;
      scan_in     = scan_ff;
      rd_vld_in   = 1'b0;
      rd_idx_in   = scan_ff[IW-1:0];
      found_in    = found_ff;
      pend_in     = pend_ff;
      best_idx_in = best_idx_ff;
      best_pr_in  = best_pr_ff;
      best_arr_in = best_arr_ff;
      best_rem_in = best_rem_ff;
      best_bur_in = best_bur_ff;
      best_fin_in = best_fin_ff;
      next_arr_in = next_arr_ff;
      prev_vld_in = prev_vld_ff;
      prev_arr_in = prev_arr_ff;
      prev_idx_in = prev_idx_ff;
      ocnt_in     = ocnt_ff;
      rsp_vld_in  = rsp_vld_ff;
      num_in      = num_ff;
      fin_in      = fin_ff;
      tat_in      = tat_ff;
      wt_in       = wt_ff;
      last_in     = last_ff;

      // pipelined read issue while scanning
      if ((state_ff == ST_SCAN || state_ff == ST_RSCAN) && scan_ff != cnt_ff) begin
         rd_vld_in = 1'b1;
         scan_in   = scan_ff + CW'(1);
      end

      case (state_ff)
         ST_LOAD: begin
            if (popped) begin
               if (q_entry.store) begin
                  cnt_in = cnt_ff + CW'(1);
               end
               if (q_entry.last_task) begin
                  t_in     = '0;
                  scan_in  = '0;
                  found_in = 1'b0;
                  pend_in  = 1'b0;
               end
            end
         end
         ST_SCAN: begin
            if (rd_vld_ff && e_rem != '0) begin
               if ({1'b0, e_arr} <= t_ff) begin
                  if (!found_ff || e_pr < best_pr_ff
                      || (e_pr == best_pr_ff && e_arr < best_arr_ff)) begin
                     found_in    = 1'b1;
                     best_idx_in = rd_idx_ff;
                     best_pr_in  = e_pr;
                     best_arr_in = e_arr;
                     best_rem_in = e_rem;
                     best_fin_in = e_fin;
                  end
               end else if (!pend_ff || e_arr < next_arr_ff) begin
                  pend_in     = 1'b1;
                  next_arr_in = e_arr;
               end
            end
            if (scan_done) begin
               scan_in  = '0;
               found_in = 1'b0;
               pend_in  = 1'b0;
               if (!found_ff && pend_ff) begin
                  t_in = {1'b0, next_arr_ff};
               end else if (!found_ff) begin
                  prev_vld_in = 1'b0;
                  ocnt_in     = '0;
               end
            end
         end
         ST_UPDATE: begin
            t_in = t_ff + TIME_W'(1);
         end
         ST_RSCAN: begin
            if (rd_vld_ff
                && (!prev_vld_ff || {e_arr, rd_idx_ff} > {prev_arr_ff, prev_idx_ff})
                && (!found_ff || {e_arr, rd_idx_ff} < {best_arr_ff, best_idx_ff})) begin
               found_in    = 1'b1;
               best_idx_in = rd_idx_ff;
               best_arr_in = e_arr;
               best_bur_in = e_bur;
               best_fin_in = e_fin;
            end
            if (scan_done) begin
               if (found_ff) begin
                  rsp_vld_in = 1'b1;
                  num_in     = NUM_W'(best_idx_ff);
                  fin_in     = best_fin_ff;
                  tat_in     = tat_calc;
                  wt_in      = tat_calc - {{(TIME_W-BURST_W){1'b0}}, best_bur_ff};
                  last_in    = (ocnt_ff == cnt_ff - CW'(1));
               end else begin
                  cnt_in = '0;
               end
            end
         end
         ST_ROUT: begin
            if (rsp_take) begin
               rsp_vld_in  = 1'b0;
               prev_vld_in = 1'b1;
               prev_arr_in = best_arr_ff;
               prev_idx_in = best_idx_ff;
               ocnt_in     = ocnt_ff + CW'(1);
               scan_in     = '0;
               found_in    = 1'b0;
               if (last_ff) begin
                  cnt_in = '0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         cnt_ff     <= '0;
         scan_ff    <= '0;
         rd_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         scan_ff    <= scan_in;
         rd_vld_ff  <= rd_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      t_ff        <= t_in;
      rd_idx_ff   <= rd_idx_in;
      found_ff    <= found_in;
      pend_ff     <= pend_in;
      best_idx_ff <= best_idx_in;
      best_pr_ff  <= best_pr_in;
      best_arr_ff <= best_arr_in;
      best_rem_ff <= best_rem_in;
      best_bur_ff <= best_bur_in;
      best_fin_ff <= best_fin_in;
      next_arr_ff <= next_arr_in;
      prev_vld_ff <= prev_vld_in;
      prev_arr_ff <= prev_arr_in;
      prev_idx_ff <= prev_idx_in;
      ocnt_ff     <= ocnt_in;
      num_ff      <= num_in;
      fin_ff      <= fin_in;
      tat_ff      <= tat_in;
      wt_ff       <= wt_in;
      last_ff     <= last_in;
   end

   assign rsp_ch.valid       = rsp_vld_ff;
   assign rsp_ch.task_number = num_ff;
   assign rsp_ch.finish_time = fin_ff;
   assign rsp_ch.turnaround  = tat_ff;
   assign rsp_ch.waiting     = wt_ff;
   assign rsp_ch.last_report = last_ff;

   `PPS_ASSERT_NOW(a_rsp_only_in_out, rsp_vld_ff, state_ff == ST_ROUT, "report outside output phase")
   `PPS_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_ff <= CW'(MAX_TASKS), "task count beyond capacity")
   `PPS_ASSERT_NEXT(a_tick_step, state_ff == ST_UPDATE, t_ff == $past(t_ff) + TIME_W'(1), "tick not advanced after service")
   `PPS_ASSERT_NOW(a_pop_in_load, popped, state_ff == ST_LOAD, "queue popped while busy")
endmodule

>>> rtl/core/preemptive_priority_scheduler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_top
// preemptive priority scheduler: load tasks, simulate ticks, report results
// ----------------------------------------------------------------------------
// Tasks are loaded one beat per cycle on req_ch while the front-end queue has
// room; a beat's load position is its task number. The beat with last_task set
// starts a tick simulation of the set; beats beyond MAX_TASKS are dropped but
// their last_task flag still counts. Each simulated tick costs one scan of the
// stored tasks plus an update state that charges the served task; stretches with
// no ready task are skipped in a single scan. Reporting walks the tasks in arrival
// order, one scan per report beat, and each beat waits on rsp_ch until taken.
// Load beats of the next set are queued two deep while a simulation runs, then
// held off until the last report beat has gone. Each scan reads the task store
// through its single read port, which has registered read data.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_top #(
   parameter int MAX_TASKS = 16
) (
   input  logic      clock,
   input  logic      reset,
   pps_req_if.sink   req_ch,
   pps_rsp_if.source rsp_ch
);
   import pps_pkg::*;

   // queue handoff between front end and scheduler
   logic     q_valid;
   logic     q_pop;
   task_type q_entry;

   // front end: acceptance, overflow flag, two-deep queue
   pps_front #(.MAX_TASKS(MAX_TASKS)) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .q_valid (q_valid),
      .q_pop   (q_pop),
      .q_entry (q_entry)
   );

   // back end: task store, tick simulation and report sequencing
   pps_back #(.MAX_TASKS(MAX_TASKS)) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_pop   (q_pop),
      .q_entry (q_entry),
      .rsp_ch  (rsp_ch)
   );
endmodule

>>> tb/pps_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_tb_if
// testbench-side beat types for the scheduler channels
// ----------------------------------------------------------------------------
// the block's own channel interfaces come from the rtl; this file only holds
// the beat structs shared by the stimulus and the checker
// ----------------------------------------------------------------------------
package pps_tb_pkg;
   import pps_pkg::*;

   typedef struct packed {
      logic [ARR_W-1:0]   arrival_time;
      logic [BURST_W-1:0] burst_time;
      logic [PRIO_W-1:0]  task_priority;
      logic               last_task;
   } load_beat_t;

   typedef struct packed {
      logic [NUM_W-1:0]  task_number;
      logic [TIME_W-1:0] finish_time;
      logic [TIME_W-1:0] turnaround;
      logic [TIME_W-1:0] waiting;
      logic              last_report;
   } report_beat_t;
endpackage

>>> tb/pps_schedule_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_schedule_checker
// watches both channels, predicts task reports and compares them
// ----------------------------------------------------------------------------
module pps_schedule_checker #(
   parameter int MAX_TASKS = 16
) (
   input  logic      clock,
   input  logic      reset,
   pps_req_if        req_ch,
   pps_rsp_if        rsp_ch,
   output int        fail_count,
   output int        reports_pending,
   output int        reports_seen,
   output int        sets_seen
);
   import pps_pkg::*;
   import pps_tb_pkg::*;

   int unsigned  arr_q[MAX_TASKS];
   int unsigned  burst_q[MAX_TASKS];
   int unsigned  left_q[MAX_TASKS];
   int unsigned  prio_q[MAX_TASKS];
   int unsigned  fin_q[MAX_TASKS];
   int unsigned  order_q[MAX_TASKS];
   int unsigned  task_count;
   report_beat_t expected_reports[$];

   initial begin
      fail_count = 0;
      reports_seen = 0;
      sets_seen = 0;
   end

   assign reports_pending = expected_reports.size();

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   // stable insertion by arrival
   task automatic store_task(input load_beat_t b);
      int unsigned slot;
      int unsigned pos;
      slot = task_count;
      pos = 0;
      if (slot >= MAX_TASKS) return;
      arr_q[slot] = b.arrival_time;
      burst_q[slot] = b.burst_time;
      left_q[slot] = b.burst_time;
      prio_q[slot] = b.task_priority;
      fin_q[slot] = b.arrival_time;
      while (pos < slot && arr_q[order_q[pos]] <= b.arrival_time) pos++;
      for (int k = slot; k > pos; k--) order_q[k] = order_q[k-1];
      order_q[pos] = slot;
      task_count = slot + 1;
   endtask

   task automatic run_schedule();
      int unsigned tick;
      bit          found;
      bit          waiting_any;
      int unsigned pick;
      int unsigned pick_prio;
      int unsigned next_arr;
      int unsigned id;
      report_beat_t r;
      tick = 0;
      forever begin
         found = 0;
         waiting_any = 0;
         pick = 0;
         pick_prio = 0;
         next_arr = 0;
         for (int k = 0; k < task_count; k++) begin
            id = order_q[k];
            if (left_q[id] == 0) continue;
            if (arr_q[id] <= tick) begin
               if (!found || prio_q[id] < pick_prio) begin
                  found = 1;
                  pick = id;
                  pick_prio = prio_q[id];
               end
            end else if (!waiting_any || arr_q[id] < next_arr) begin
               waiting_any = 1;
               next_arr = arr_q[id];
            end
         end
         if (found) begin
            left_q[pick]--;
            if (left_q[pick] == 0) fin_q[pick] = tick + 1;
            tick++;
         end else if (waiting_any) begin
            tick = next_arr;
         end else begin
            break;
         end
      end
      for (int k = 0; k < task_count; k++) begin
         id = order_q[k];
         r.task_number = id[NUM_W-1:0];
         r.finish_time = TIME_W'(fin_q[id]);
         r.turnaround = TIME_W'(fin_q[id] - arr_q[id]);
         r.waiting = TIME_W'(fin_q[id] - arr_q[id] - burst_q[id]);
         r.last_report = (k + 1 == task_count);
         expected_reports.push_back(r);
      end
      task_count = 0;
   endtask

   always @(posedge clock) begin
      load_beat_t   lb;
      report_beat_t want;
      if (reset) begin
         task_count = 0;
         expected_reports.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            reports_seen++;
            if (expected_reports.size() == 0) begin
               report_mismatch("unexpected report beat, task", rsp_ch.task_number, 0);
            end else begin
               want = expected_reports.pop_front();
               if (rsp_ch.task_number !== want.task_number)
                  report_mismatch("task_number", rsp_ch.task_number, want.task_number);
               if (rsp_ch.finish_time !== want.finish_time)
                  report_mismatch("finish_time", rsp_ch.finish_time, want.finish_time);
               if (rsp_ch.turnaround !== want.turnaround)
                  report_mismatch("turnaround", rsp_ch.turnaround, want.turnaround);
               if (rsp_ch.waiting !== want.waiting)
                  report_mismatch("waiting", rsp_ch.waiting, want.waiting);
               if (rsp_ch.last_report !== want.last_report)
                  report_mismatch("last_report", rsp_ch.last_report, want.last_report);
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            lb = '{req_ch.arrival_time, req_ch.burst_time, req_ch.task_priority,
                   req_ch.last_task};
            store_task(lb);
            if (lb.last_task) begin
               sets_seen++;
               run_schedule();
            end
         end
      end
   end
endmodule

>>> tb/tb_preemptive_priority_scheduler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_preemptive_priority_scheduler_top
// stimulus and verdict for the preemptive priority scheduler
// ----------------------------------------------------------------------------
// loads task sets over req_ch and drains reports from rsp_ch; a separate
// checker predicts every report beat and counts mismatches. directed sets
// cover field extremes, zero bursts, idle gaps, ties and an overfull set,
// then random sets run under three idling phases
// ----------------------------------------------------------------------------
module tb_preemptive_priority_scheduler_top;
   import pps_pkg::*;
   import pps_tb_pkg::*;

   localparam int MAX_TASKS  = 16;
   localparam int CYCLE_CAP  = 3000000;
   localparam int DRAIN_GAP  = 50;

   logic clock;
   logic reset;
   int   fail_count;
   int   reports_pending;
   int   reports_seen;
   int   sets_seen;
   int   cycle_count;
   int   beats_sent;
   int   send_idle_pct;
   int   recv_idle_pct;

   pps_req_if req_ch ();
   pps_rsp_if rsp_ch ();

   preemptive_priority_scheduler_top #(.MAX_TASKS(MAX_TASKS)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   pps_schedule_checker #(.MAX_TASKS(MAX_TASKS)) checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .fail_count      (fail_count),
      .reports_pending (reports_pending),
      .reports_seen    (reports_seen),
      .sets_seen       (sets_seen)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // watchdog: generous cap over the slowest legal run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL preemptive_priority_scheduler_top");
         $finish;
      end
   end

   // receiver stalls, changed on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // one load beat, held until accepted; random gap before it
   task automatic send_beat(input load_beat_t b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.arrival_time  <= b.arrival_time;
      req_ch.burst_time    <= b.burst_time;
      req_ch.task_priority <= b.task_priority;
      req_ch.last_task     <= b.last_task;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      beats_sent++;
      @(negedge clock);
   endtask

   // drop valid after the final beat of a run of sets
   task automatic release_bus();
      req_ch.valid <= 1'b0;
   endtask

   // a set of n tasks; narrow arrival spread keeps the simulation short,
   // occasionally widened, and occasionally offset so the high arrival bits toggle
   task automatic send_random_set(input int n);
      load_beat_t b;
      int unsigned base;
      int unsigned spread;
      base = ($urandom_range(9) == 0) ? $urandom_range(65535 - 300) : 0;
      spread = $urandom_range(3) == 0 ? 300 : 40;
      for (int k = 0; k < n; k++) begin
         b.arrival_time  = 16'(base + $urandom_range(spread));
         b.burst_time    = ($urandom_range(19) == 0) ? 8'($urandom_range(255))
                                                     : 8'($urandom_range(12));
         b.task_priority = ($urandom_range(3) == 0) ? 8'($urandom_range(3))
                                                    : 8'($urandom_range(255));
         b.last_task     = (k == n - 1);
         send_beat(b);
      end
   endtask

   task automatic wait_drained();
      while (reports_pending != 0) @(negedge clock);
   endtask

   initial begin
      load_beat_t b;
      int         n;
      cycle_count = 0;
      beats_sent = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.arrival_time = '0;
      req_ch.burst_time = '0;
      req_ch.task_priority = '0;
      req_ch.last_task = 1'b0;
      rsp_ch.ready = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // single task, all fields at their maxima
      send_beat('{16'hFFFF, 8'hFF, 8'hFF, 1'b1});
      // single task with zero burst at tick 0
      send_beat('{16'h0000, 8'h00, 8'h00, 1'b1});
      // zero burst among others, idle gap before a late arrival, and ties
      send_beat('{16'd0,   8'd3, 8'd5,   1'b0});
      send_beat('{16'd2,   8'd0, 8'd0,   1'b0});
      send_beat('{16'd1,   8'd4, 8'd5,   1'b0});
      send_beat('{16'd1,   8'd2, 8'd5,   1'b0});
      send_beat('{16'd100, 8'd2, 8'd0,   1'b0});
      send_beat('{16'd3,   8'd2, 8'd255, 1'b1});
      // preemption: a higher priority task arrives mid burst
      send_beat('{16'd0,   8'd10, 8'd200, 1'b0});
      send_beat('{16'd4,   8'd3,  8'd1,   1'b1});
      // pause: let every report drain before the full set
      release_bus();
      wait_drained();
      repeat (DRAIN_GAP) @(negedge clock);
      // overfull set: 18 beats, the last two dropped, the final one still starts
      for (int k = 0; k < 18; k++) begin
         b.arrival_time  = 16'(17 - k);
         b.burst_time    = 8'(k % 4);
         b.task_priority = 8'(k % 3);
         b.last_task     = (k == 17);
         send_beat(b);
      end

      // random sets under three idling phases
      for (int phase_i = 0; phase_i < 3; phase_i++) begin
         send_idle_pct = (phase_i == 0) ? 18 : (phase_i == 1) ? 80 : 0;
         recv_idle_pct = (phase_i == 0) ? 80 : (phase_i == 1) ? 18 : 0;
         while (beats_sent < 30 + 125 * (phase_i + 1)) begin
            n = ($urandom_range(7) == 0) ? MAX_TASKS : $urandom_range(1, 8);
            send_random_set(n);
         end
      end

      release_bus();
      wait_drained();
      repeat (DRAIN_GAP) @(negedge clock);

      $display("load beats sent %0d, task sets %0d, report beats checked %0d",
               beats_sent, sets_seen, reports_seen);
      $display("directed extremes, overfull set and three stall phases run");
      if (fail_count == 0 && reports_pending == 0) begin
         $display("PASS preemptive_priority_scheduler_top");
      end else begin
         $display("FAIL preemptive_priority_scheduler_top");
      end
      $finish;
   end
endmodule

>>> preemptive_priority_scheduler_top.f
+incdir+rtl/core
rtl/core/pps_pkg.sv
rtl/core/pps_req_if.sv
rtl/core/pps_rsp_if.sv
rtl/core/pps_ram.sv
rtl/core/pps_front.sv
rtl/core/pps_back.sv
rtl/core/preemptive_priority_scheduler_top.sv
tb/pps_tb_if.sv
tb/pps_schedule_checker.sv
tb/tb_preemptive_priority_scheduler_top.sv
